@@ rtl/sbph_pkg.sv @@
// Shared types and field widths for the spectrum bar peak-hold block.
package sbph_pkg;

  localparam int BAND_W  = 5;
  localparam int MAG_W   = 8;
  localparam int LEVEL_W = 4;

  // Smoothed levels and unclamped bar heights are both 8 bits wide.
  localparam int SMOOTH_W = 8;

  typedef enum logic {
    KIND_MAG   = 1'b0,
    KIND_DECAY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [BAND_W-1:0]   band;
    logic [MAG_W-1:0]    magnitude;
  } in_item_t;

  // Contents of the input register as seen by the band core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_beat_t;

  // Result offered by the band core for the item held in the input register.
  typedef struct packed {
    logic                emit;
    logic [BAND_W-1:0]   band_out;
    logic [LEVEL_W-1:0]  bar_level;
    logic [LEVEL_W-1:0]  peak_level;
  } res_beat_t;

endpackage

@@ rtl/sbph_if.sv @@
// Valid/ready channel interfaces for magnitude input beats and result beats.
interface sbph_in_if
  import sbph_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [BAND_W-1:0]  band;
  logic [MAG_W-1:0]   magnitude;

  modport source (output valid, kind, band, magnitude, input ready);
  modport sink   (input valid, kind, band, magnitude, output ready);
endinterface

interface sbph_out_if
  import sbph_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BAND_W-1:0]   band_out;
  logic [LEVEL_W-1:0]  bar_level;
  logic [LEVEL_W-1:0]  peak_level;

  modport source (output valid, band_out, bar_level, peak_level, input ready);
  modport sink   (input valid, band_out, bar_level, peak_level, output ready);
endinterface

@@ rtl/spectrum_bar_peak_hold.sv @@
// Top level of the per-band spectrum bar meter with peak hold and decay.
//
// The input channel in_i carries beats of two kinds. A magnitude beat names a
// band and brings an 8-bit magnitude; the block smooths it into the band's
// stored level as (3*previous + new)/4, scales that to a bar height, raises the
// band's held peak if the bar is above it (clamped to BAR_ROWS-1) and sends
// one result beat on out_o with the band, bar height and peak. A decay beat
// lowers every nonzero held peak by one and sends nothing; so does a magnitude
// beat whose band is not below BAND_COUNT.
//
// An accepted beat is worked on from the input register, and its result is
// loaded into the output register when the beat leaves the input register.
// Throughput is one beat per cycle while out_o does not stall, set by the
// read-modify-write of the band state, written as each beat is consumed.
// Back-to-back beats for the same band see each other's updates.
//
// Reset clears both per-band stores, the held peaks and the smoothed levels,
// and empties both registers. When the receiver stalls, the output register
// holds its result and the input register holds one more beat; ready on in_i
// drops only when both are full. Decay beats still drain while out_o stalls.
module spectrum_bar_peak_hold
  import sbph_pkg::*;
#(
  parameter int BAND_COUNT = 32,
  parameter int BAR_ROWS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbph_in_if.sink    in_i,
  sbph_out_if.source out_o
);

  in_beat_t  beat;
  res_beat_t res;
  logic      out_free;
  logic      consume;

  // The held beat leaves the input register once its result, if it has one,
  // has room in the output register.
  assign consume = beat.valid && (!res.emit || out_free);

  sbph_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .consume_i (consume),
    .beat_o    (beat)
  );

  sbph_band_core #(
    .BAND_COUNT (BAND_COUNT),
    .BAR_ROWS   (BAR_ROWS)
  ) u_band_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .consume_i (consume),
    .res_o     (res)
  );

  sbph_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .consume_i (consume),
    .free_o    (out_free),
    .out_o     (out_o)
  );

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> beat.valid)
    else $error("accepted beat missing from the input register");

  a_result_offered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && res.emit |=> out_o.valid)
    else $error("consumed sample produced no result beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && res.emit |-> out_free)
    else $error("result loaded over an unread result");

endmodule

@@ rtl/sbph_in_stage.sv @@
// Input register that captures one beat from the input channel.
module sbph_in_stage
  import sbph_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  sbph_in_if.sink         in_i,
  input  logic            consume_i,
  output in_beat_t        beat_o
);

  logic     valid_q;
  in_item_t item_q;
  logic     load;

  // A new beat may enter when the register is empty or drains this cycle.
  assign in_i.ready = !valid_q || consume_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.kind      <= kind_e'(in_i.kind);
      item_q.band      <= in_i.band;
      item_q.magnitude <= in_i.magnitude;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.item  = item_q;

endmodule

@@ rtl/sbph_band_core.sv @@
// Per-band smoothing, bar scaling and peak-hold state with its update logic.
module sbph_band_core
  import sbph_pkg::*;
#(
  parameter int BAND_COUNT = 32,
  parameter int BAR_ROWS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  beat_i,
  input  logic      consume_i,
  output res_beat_t res_o
);

  // Only bands reachable through the band field need storage.
  localparam int BAND_SPAN = 1 << BAND_W;
  localparam int DEPTH     = (BAND_COUNT < BAND_SPAN) ? BAND_COUNT : BAND_SPAN;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W     = BAND_W + 1;
  localparam int PEAK_MAX  = BAR_ROWS - 1;
  localparam int PEAK_W    = $clog2(BAR_ROWS);
  localparam int RAW_DIV   = 255 / PEAK_MAX;
  localparam int BAR_DIV   = (RAW_DIV == 0) ? 1 : RAW_DIV;
  // Reciprocal with 16 fraction bits; exact for every 8-bit level.
  localparam int RECIP_SH  = 16;
  localparam int RECIP     = ((1 << RECIP_SH) + BAR_DIV - 1) / BAR_DIV;
  localparam int SUM_W     = SMOOTH_W + 2;
  localparam int PROD_W    = SMOOTH_W + RECIP_SH + 1;

  logic [SMOOTH_W-1:0] level_q [DEPTH];
  logic [PEAK_W-1:0]   peak_q  [DEPTH];

  logic [IDX_W-1:0]    idx;
  logic                is_decay;
  logic                in_range;
  logic                emit;
  logic [SMOOTH_W-1:0] level_prev;
  logic [SUM_W-1:0]    level_sum;
  logic [SMOOTH_W-1:0] level_new;
  logic [PROD_W-1:0]   bar_prod;
  logic [SMOOTH_W-1:0] bar;
  logic [PEAK_W-1:0]   peak_cur;
  logic [PEAK_W-1:0]   peak_new;
  logic                raise;
  logic [PEAK_W-1:0]   peak_after;
  logic [SMOOTH_W-1:0] peak_ext;

  assign idx      = beat_i.item.band[IDX_W-1:0];
  assign is_decay = (beat_i.item.kind == KIND_DECAY);
  assign in_range = ({1'b0, beat_i.item.band} < CMP_W'(DEPTH));
  assign emit     = beat_i.valid && !is_decay && in_range;

  always_comb begin
    level_prev = level_q[idx];
    level_sum  = SUM_W'(level_prev) * SUM_W'(3) + SUM_W'(beat_i.item.magnitude);
    level_new  = level_sum[SUM_W-1:2];
    bar_prod   = PROD_W'(level_new) * PROD_W'(RECIP);
    bar        = bar_prod[RECIP_SH +: SMOOTH_W];
    peak_cur   = peak_q[idx];
    raise      = (bar > SMOOTH_W'(peak_cur));
    peak_new   = (bar < SMOOTH_W'(PEAK_MAX)) ? bar[PEAK_W-1:0] : PEAK_W'(PEAK_MAX);
    peak_after = raise ? peak_new : peak_cur;
    peak_ext   = SMOOTH_W'(peak_after);
  end

  assign res_o.emit       = emit;
  assign res_o.band_out   = beat_i.item.band;
  assign res_o.bar_level  = bar[LEVEL_W-1:0];
  assign res_o.peak_level = peak_ext[LEVEL_W-1:0];

  // A decay tick steps every nonzero peak down by one; a sample updates its band.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        level_q[i] <= '0;
        peak_q[i]  <= '0;
      end
    end else if (consume_i) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (beat_i.valid && is_decay) begin
          if (peak_q[i] != '0) begin
            peak_q[i] <= peak_q[i] - PEAK_W'(1);
          end
        end else if (emit && (idx == IDX_W'(i))) begin
          level_q[i] <= level_new;
          if (raise) begin
            peak_q[i] <= peak_new;
          end
        end
      end
    end
  end

  a_peak_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q[0] <= PEAK_W'(PEAK_MAX))
    else $error("held peak of band 0 exceeds the clamp");

  a_decay_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_i && beat_i.valid && is_decay && (peak_q[0] != '0)
      |=> peak_q[0] == $past(peak_q[0]) - PEAK_W'(1))
    else $error("decay tick did not lower band 0 peak by one");

  a_raise_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_i && emit |=> peak_q[$past(idx)] == $past(peak_after))
    else $error("stored peak differs from the reported peak");

endmodule

@@ rtl/sbph_out_stage.sv @@
// Output register that holds one result beat until the receiver takes it.
module sbph_out_stage
  import sbph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_beat_t  res_i,
  input  logic       consume_i,
  output logic       free_o,
  sbph_out_if.source out_o
);

  logic      valid_q;
  res_beat_t res_q;
  logic      load;

  assign free_o = !valid_q || out_o.ready;
  assign load   = consume_i && res_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.band_out   = res_q.band_out;
  assign out_o.bar_level  = res_q.bar_level;
  assign out_o.peak_level = res_q.peak_level;

endmodule
